// ----- sv/window_average_running_min_macros.svh -----
// Assertion helpers for the window average block.
// Each expects clk and rst_n in scope.
`ifndef WINDOW_AVERAGE_RUNNING_MIN_MACROS_SVH
`define WINDOW_AVERAGE_RUNNING_MIN_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define WAR_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define WAR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/war_pkg.sv -----
package war_pkg;

    localparam int ADC_W      = 12;
    localparam int PRESS_W    = 16;
    localparam int AVG_W      = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int LEN_FIELD_W = 6;
    localparam int DIV_STEPS  = 16;
    localparam int STEP_W     = 4;

    localparam logic [1:0] OP_SAMPLE = 2'd0;
    localparam logic [1:0] OP_START  = 2'd1;
    localparam logic [1:0] OP_END    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_LENGTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESSURE_GAIN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESSURE_OFFSET = 2'd2;

    localparam logic signed [PRESS_W-1:0] PRESS_MAX = 16'sh7FFF;
    localparam logic signed [PRESS_W-1:0] PRESS_MIN = -16'sh8000;
    localparam logic [CFG_DATA_W-1:0] GAIN_RESET = 16'd16384;

    typedef struct packed {
        logic [1:0]       operation;
        logic [ADC_W-1:0] adc_sample;
    } in_item_t;

    typedef struct packed {
        logic signed [PRESS_W-1:0] min_pressure;
        logic [AVG_W-1:0]          average_adc;
        logic                      status;
        logic                      pressure_valid;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_MUL,
        ST_PUSH,
        ST_SCAN,
        ST_FIN,
        ST_OUT
    } war_state_t;

endpackage

// ----- sv/window_average_running_min.sv -----
// Windowed ADC averaging with a running minimum of recent window pressures.
// Input channel (in_valid/in_ready, in_data): one transfer per event. A sample
// or a window start is absorbed and produces nothing. A window end starts the
// result sequence and drops in_ready until its result is taken.
// Output channel (out_valid/out_ready, out_data): one result per window end.
// Window end: a restoring divide (one quotient bit per cycle), a multiply, a
// history write, a minimum scan over the history memory (one registered read
// per cycle) and the load of the result into the output register.
// An empty window skips all of that and shows its result the cycle after the
// transfer. The result stays in the output register while out_ready is low;
// the block takes no new item until it leaves.
// Write configuration (cfg_write, cfg_index, cfg_data) only while idle; the
// block does not enforce it. Writing buffer_length clears the history at once
// through per-entry valid bits; an invalid entry reads as the maximum pressure.
// Reset (rst_n low, asynchronous) closes the window, clears the sum, count,
// history, write index and the minimum, and loads register defaults.
module window_average_running_min
    import war_pkg::*;
#(
    parameter int HISTORY_DEPTH = 32,
    parameter int COUNT_MAX     = 65535
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_item_t              in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_item_t             out_data,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CW = $clog2(COUNT_MAX + 1);          // count width
    localparam int SW = ADC_W + CW;                     // sum width
    localparam int LW = $clog2(HISTORY_DEPTH + 1);      // length width
    localparam int IW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int CLW = 9;                             // clamp compare width

    war_state_t state_reg, state_next;

    // configuration
    logic [LW-1:0]              len_reg;
    logic [CFG_DATA_W-1:0]      gain_reg;
    logic signed [PRESS_W-1:0]  offset_reg;

    // window accumulation
    logic [SW-1:0]  window_sum_reg;
    logic [CW-1:0]  window_count_reg;
    logic           window_open_reg;

    // divider: remainder and shifting dividend/quotient word
    logic [CW-1:0]      rem_reg;
    logic [AVG_W-1:0]   quo_reg;
    logic [STEP_W-1:0]  step_reg;
    logic [PRESS_W-1:0] scaled_reg;

    // history and scan
    logic signed [PRESS_W-1:0] hist_mem [HISTORY_DEPTH];
    logic [HISTORY_DEPTH-1:0]  hist_valid_reg;
    logic [IW-1:0]             hist_idx_reg;
    logic [LW-1:0]             scan_cnt_reg;
    logic                      rd_pend_reg;
    logic signed [PRESS_W-1:0] rd_data_reg;
    logic                      rd_valid_reg;
    logic signed [PRESS_W-1:0] min_acc_reg;
    logic signed [PRESS_W-1:0] cur_min_reg;
    logic                      have_result_reg;
    out_item_t                 out_data_reg;

    // control decoded from state
    logic in_xfer, do_div, do_mul, do_push, do_scan, do_fin;
    logic is_end, is_empty;

    // combinational datapath
    logic [CW:0]               trial;
    logic                      trial_ge;
    logic [CW-1:0]             rem_next;
    logic signed [PRESS_W+1:0] press_wide;
    logic signed [PRESS_W-1:0] press_sat;
    logic [IW-1:0]             wr_idx;
    logic [LW-1:0]             wr_idx_inc;
    logic [IW-1:0]             hist_idx_next;
    logic                      scan_more;
    logic [IW-1:0]             rd_addr;
    logic signed [PRESS_W-1:0] rd_entry;
    logic [CLW-1:0]            len_raw;
    logic [CLW-1:0]            len_clamped;

    assign is_end   = (in_data.operation == OP_END);
    assign is_empty = (window_count_reg == '0);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && is_end)
                begin
                    state_next = is_empty ? ST_OUT : ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:  state_next = ST_PUSH;
            ST_PUSH: state_next = ST_SCAN;
            ST_SCAN:
            begin
                if (scan_cnt_reg == len_reg)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:  state_next = ST_OUT;
            ST_OUT:
            begin
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs and unit enables
    always_comb
    begin
        in_ready  = 1'b0;
        out_valid = 1'b0;
        do_div    = 1'b0;
        do_mul    = 1'b0;
        do_push   = 1'b0;
        do_scan   = 1'b0;
        do_fin    = 1'b0;
        case (state_reg)
            ST_IDLE: in_ready  = 1'b1;
            ST_DIV:  do_div    = 1'b1;
            ST_MUL:  do_mul    = 1'b1;
            ST_PUSH: do_push   = 1'b1;
            ST_SCAN: do_scan   = 1'b1;
            ST_FIN:  do_fin    = 1'b1;
            ST_OUT:  out_valid = 1'b1;
            default: in_ready  = 1'b0;
        endcase
    end

    assign in_xfer  = in_valid && in_ready;
    assign out_data = out_data_reg;

    // Restoring divide step: shift in the next dividend bit, subtract if it fits.
    assign trial    = {rem_reg, quo_reg[AVG_W-1]};
    assign trial_ge = (trial >= {1'b0, window_count_reg});
    assign rem_next = trial_ge ? CW'(trial - {1'b0, window_count_reg}) : trial[CW-1:0];

    // Offset plus scaled average, saturated to the pressure range.
    assign press_wide = $signed({2'b00, scaled_reg})
                      + $signed({{2{offset_reg[PRESS_W-1]}}, offset_reg});
    always_comb
    begin
        if (press_wide > $signed({2'b00, PRESS_MAX}))
        begin
            press_sat = PRESS_MAX;
        end
        else if (press_wide < $signed({2'b11, PRESS_MIN}))
        begin
            press_sat = PRESS_MIN;
        end
        else
        begin
            press_sat = press_wide[PRESS_W-1:0];
        end
    end

    // Circular write index, wrapped at the configured length.
    assign wr_idx        = (LW'(hist_idx_reg) >= len_reg) ? '0 : hist_idx_reg;
    assign wr_idx_inc    = LW'(wr_idx) + LW'(1);
    assign hist_idx_next = (wr_idx_inc == len_reg) ? '0 : wr_idx_inc[IW-1:0];

    // Scan read address; hold it in range once all entries are issued.
    assign scan_more = (scan_cnt_reg < len_reg);
    assign rd_addr   = scan_more ? scan_cnt_reg[IW-1:0] : '0;
    assign rd_entry  = rd_valid_reg ? rd_data_reg : PRESS_MAX;

    // Clamp a written buffer length to 1..HISTORY_DEPTH.
    assign len_raw = CLW'(cfg_data[LEN_FIELD_W-1:0]);
    always_comb
    begin
        if (len_raw == '0)
        begin
            len_clamped = CLW'(1);
        end
        else if (len_raw > CLW'(HISTORY_DEPTH))
        begin
            len_clamped = CLW'(HISTORY_DEPTH);
        end
        else
        begin
            len_clamped = len_raw;
        end
    end

    // history memory, registered read
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            hist_mem[wr_idx] <= press_sat;
        end
        rd_data_reg <= hist_mem[rd_addr];
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            len_reg          <= LW'(1);
            gain_reg         <= GAIN_RESET;
            offset_reg       <= '0;
            window_sum_reg   <= '0;
            window_count_reg <= '0;
            window_open_reg  <= 1'b0;
            hist_valid_reg   <= '0;
            hist_idx_reg     <= '0;
            rd_pend_reg      <= 1'b0;
            rd_valid_reg     <= 1'b0;
            cur_min_reg      <= '0;
            have_result_reg  <= 1'b0;
            step_reg         <= '0;
            scan_cnt_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_BUFFER_LENGTH:
                    begin
                        len_reg        <= LW'(len_clamped);
                        hist_valid_reg <= '0;
                        hist_idx_reg   <= '0;
                    end
                    CFG_PRESSURE_GAIN:   gain_reg   <= cfg_data;
                    CFG_PRESSURE_OFFSET: offset_reg <= $signed(cfg_data);
                    default: ;
                endcase
            end

            if (in_xfer)
            begin
                case (in_data.operation)
                    OP_SAMPLE:
                    begin
                        if (window_open_reg && window_count_reg < CW'(COUNT_MAX))
                        begin
                            window_sum_reg   <= window_sum_reg + SW'(in_data.adc_sample);
                            window_count_reg <= window_count_reg + CW'(1);
                        end
                    end
                    OP_START:
                    begin
                        window_sum_reg   <= '0;
                        window_count_reg <= '0;
                        window_open_reg  <= 1'b1;
                    end
                    OP_END:
                    begin
                        window_open_reg <= 1'b0;
                        step_reg        <= '0;
                    end
                    default: ;
                endcase
            end

            if (do_div)
            begin
                step_reg <= step_reg + STEP_W'(1);
            end

            if (do_push)
            begin
                hist_valid_reg[wr_idx] <= 1'b1;
                hist_idx_reg           <= hist_idx_next;
                scan_cnt_reg           <= '0;
                rd_pend_reg            <= 1'b0;
            end

            if (do_scan)
            begin
                rd_valid_reg <= hist_valid_reg[rd_addr];
                rd_pend_reg  <= scan_more;
                if (scan_more)
                begin
                    scan_cnt_reg <= scan_cnt_reg + LW'(1);
                end
            end

            if (do_fin)
            begin
                cur_min_reg     <= min_acc_reg;
                have_result_reg <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_xfer && is_end)
        begin
            rem_reg <= window_sum_reg[SW-1:ADC_W];
            quo_reg <= {window_sum_reg[ADC_W-1:0], 4'b0000};
            if (is_empty)
            begin
                out_data_reg.min_pressure   <= cur_min_reg;
                out_data_reg.average_adc    <= '0;
                out_data_reg.status         <= 1'b1;
                out_data_reg.pressure_valid <= have_result_reg;
            end
        end

        if (do_div)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[AVG_W-2:0], trial_ge};
        end

        if (do_mul)
        begin
            scaled_reg <= PRESS_W'((2 * AVG_W)'(quo_reg) * (2 * AVG_W)'(gain_reg) >> AVG_W);
        end

        if (do_push)
        begin
            min_acc_reg <= PRESS_MAX;
        end

        if (do_scan && rd_pend_reg && (rd_entry < min_acc_reg))
        begin
            min_acc_reg <= rd_entry;
        end

        if (do_fin)
        begin
            out_data_reg.min_pressure   <= min_acc_reg;
            out_data_reg.average_adc    <= quo_reg;
            out_data_reg.status         <= 1'b0;
            out_data_reg.pressure_valid <= 1'b1;
        end
    end

endmodule

// ----- sv/war_checker.sv -----
`include "window_average_running_min_macros.svh"

module war_checker
    import war_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input in_item_t  in_data,
    input logic      out_valid,
    input logic      out_ready,
    input out_item_t out_data
);

    `WAR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")

    `WAR_ASSERT_SAME(a_busy_with_result, out_valid, !in_ready, "input taken with result pending")

    `WAR_ASSERT_NEXT(a_end_blocks, in_valid && in_ready && in_data.operation == OP_END, !in_ready, "window end did not block input")

    `WAR_ASSERT_SAME(a_empty_avg, out_valid && out_data.status, out_data.average_adc == '0, "empty window with nonzero average")

    `WAR_ASSERT_SAME(a_update_valid, out_valid && !out_data.status, out_data.pressure_valid, "updated result not marked valid")

endmodule

bind window_average_running_min war_checker u_war_checker (.*);

// ----- tb/sv/window_min_checker.sv -----
`timescale 1ns / 100ps

module window_min_checker
    import war_pkg::*;
#(
    parameter int HISTORY_DEPTH = 32,
    parameter int COUNT_MAX     = 65535
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  in_item_t              in_data,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  out_item_t             out_data,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    mismatches,
    output int                    pending
);

    // Register copies.
    int unsigned               history_len;
    logic [CFG_DATA_W-1:0]     gain;
    logic signed [PRESS_W-1:0] offset;

    // Window and history state.
    logic [27:0]               window_sum;
    int unsigned               window_count;
    logic                      window_open;
    logic signed [PRESS_W-1:0] history [HISTORY_DEPTH];
    int unsigned               write_slot;
    logic signed [PRESS_W-1:0] running_min;
    logic                      have_pressure;

    out_item_t expected_windows [$];
    int        error_count = 0;

    assign mismatches = error_count;

    task automatic report_mismatch(string msg);
        error_count++;
        $display("%0t window_min_checker: %s", $realtime, msg);
    endtask

    task automatic clear_history();
        for (int i = 0; i < HISTORY_DEPTH; i++)
        begin
            history[i] = PRESS_MAX;
        end
        write_slot = 0;
    endtask

    task automatic reset_model();
        history_len   = 1;
        gain          = GAIN_RESET;
        offset        = '0;
        window_sum    = '0;
        window_count  = 0;
        window_open   = 1'b0;
        running_min   = '0;
        have_pressure = 1'b0;
        clear_history();
        expected_windows.delete();
    endtask

    task automatic take_register_write(logic [CFG_IDX_W-1:0] index,
                                       logic [CFG_DATA_W-1:0] value);
        int unsigned len;
        case (index)
            CFG_BUFFER_LENGTH:
            begin
                len = value[LEN_FIELD_W-1:0];
                if (len < 1)
                    len = 1;
                if (len > HISTORY_DEPTH)
                    len = HISTORY_DEPTH;
                history_len = len;
                clear_history();
            end
            CFG_PRESSURE_GAIN:   gain = value;
            CFG_PRESSURE_OFFSET: offset = value;
            default: ;
        endcase
    endtask

    // Linear map from 12.4 average to pressure, saturated to 16 bits signed.
    function automatic logic signed [PRESS_W-1:0] to_pressure(logic [AVG_W-1:0] avg);
        logic [31:0] scaled;
        int          p;
        scaled = avg * gain;
        p = int'(offset) + int'(scaled >> 16);
        if (p > int'(PRESS_MAX))
            p = PRESS_MAX;
        if (p < int'(PRESS_MIN))
            p = PRESS_MIN;
        return p[PRESS_W-1:0];
    endfunction

    task automatic close_window();
        out_item_t                 result;
        logic [31:0]               scaled_sum;
        logic signed [PRESS_W-1:0] lowest;
        result = '0;
        result.status = 1'b1;
        window_open = 1'b0;
        if (window_count > 0)
        begin
            scaled_sum = {window_sum, 4'b0000};
            result.average_adc = AVG_W'(scaled_sum / window_count);
            if (write_slot >= history_len)
                write_slot = 0;
            history[write_slot] = to_pressure(result.average_adc);
            write_slot = (write_slot + 1) % history_len;
            lowest = history[0];
            for (int i = 1; i < history_len; i++)
            begin
                if (history[i] < lowest)
                    lowest = history[i];
            end
            running_min   = lowest;
            have_pressure = 1'b1;
            result.status = 1'b0;
        end
        result.min_pressure   = running_min;
        result.pressure_valid = have_pressure;
        expected_windows.push_back(result);
    endtask

    task automatic absorb_event(in_item_t item);
        case (item.operation)
            OP_SAMPLE:
            begin
                if (window_open && window_count < COUNT_MAX)
                begin
                    window_sum = window_sum + item.adc_sample;
                    window_count++;
                end
            end
            OP_START:
            begin
                window_sum   = '0;
                window_count = 0;
                window_open  = 1'b1;
            end
            OP_END:  close_window();
            default: ;
        endcase
    endtask

    task automatic check_result(out_item_t got);
        out_item_t want;
        if (expected_windows.size() == 0)
        begin
            report_mismatch($sformatf("result %h with no window end pending", got));
            return;
        end
        want = expected_windows.pop_front();
        if (got.min_pressure !== want.min_pressure)
            report_mismatch($sformatf("min_pressure expected %0d got %0d",
                                      want.min_pressure, got.min_pressure));
        if (got.average_adc !== want.average_adc)
            report_mismatch($sformatf("average_adc expected %0d got %0d",
                                      want.average_adc, got.average_adc));
        if (got.status !== want.status)
            report_mismatch($sformatf("status expected %b got %b",
                                      want.status, got.status));
        if (got.pressure_valid !== want.pressure_valid)
            report_mismatch($sformatf("pressure_valid expected %b got %b",
                                      want.pressure_valid, got.pressure_valid));
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            reset_model();
        end
        else
        begin
            if (out_valid && out_ready)
                check_result(out_data);
            if (cfg_write)
                take_register_write(cfg_index, cfg_data);
            if (in_valid && in_ready)
                absorb_event(in_data);
        end
        pending <= expected_windows.size();
    end

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
    import war_pkg::*;

    localparam int HISTORY_DEPTH = 32;
    localparam int COUNT_MAX     = 65535;

    // Operation code the block must swallow without a result.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Longest window end: 16 divide steps, multiply, write, a full history scan
    // and the output load; round up generously.
    localparam int SETTLE_CYCLES = 64;
    localparam int SEGMENT_ITEMS = 75;
    localparam int SEGMENTS      = 8;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    in_item_t              in_data   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    out_item_t             out_data;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int mismatches;
    int pending;

    // Pacing knobs, percent of cycles spent idle on each side.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int items_sent     = 0;

    window_average_running_min #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .COUNT_MAX     (COUNT_MAX)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    window_min_checker #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .COUNT_MAX     (COUNT_MAX)
    ) results_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .pending    (pending)
    );

    // 10 ns clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Receiver: decide each cycle whether to take a result. Only one
    // assignment per edge, so a stall never glitches.
    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Hard stop well beyond the slowest legal run.
    initial
    begin
        #20_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic logic [ADC_W-1:0] rand_sample();
        int pick;
        pick = $urandom_range(9);
        if (pick == 0)
            return '0;
        if (pick == 1)
            return '1;
        return ADC_W'($urandom_range(4095));
    endfunction

    // Mostly short windows, some empty, a few long.
    function automatic int window_size();
        int pick;
        pick = $urandom_range(99);
        if (pick < 12)
            return 0;
        if (pick < 88)
            return $urandom_range(12, 1);
        return $urandom_range(120, 13);
    endfunction

    task automatic set_pace(int send_pct, int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    // Offer one event and hold it until the transfer. Valid stays high after
    // the transfer; the next call or a drain decides what happens to it.
    task automatic push_event(logic [1:0] op, logic [ADC_W-1:0] sample, bit counted);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{operation: op, adc_sample: sample};
        do
            @(posedge clk);
        while (!in_ready);
        if (counted)
            items_sent++;
    endtask

    // Drop valid and hold off until every window end has produced its result.
    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    // Drain, then let any remaining work finish before touching registers.
    task automatic go_idle();
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    task automatic run_window(int samples);
        push_event(OP_START, rand_sample(), 1'b1);
        repeat (samples) push_event(OP_SAMPLE, rand_sample(), 1'b1);
        push_event(OP_END, rand_sample(), 1'b1);
    endtask

    // Mostly well-formed windows with random content; the rest is noise and
    // broken sequences. Ignored events do not count toward the quota.
    task automatic random_traffic(int quota);
        int first;
        int kind;
        first = items_sent;
        while (items_sent - first < quota)
        begin
            kind = $urandom_range(99);
            if (kind < 72)
            begin
                run_window(window_size());
            end
            else if (kind < 78)
            begin
                // stray sample, usually outside any window
                push_event(OP_SAMPLE, rand_sample(), 1'b0);
            end
            else if (kind < 83)
            begin
                push_event(OP_UNUSED, rand_sample(), 1'b0);
            end
            else if (kind < 89)
            begin
                // end with no start: re-closes whatever the window still holds
                push_event(OP_END, rand_sample(), 1'b1);
            end
            else if (kind < 95)
            begin
                // restart in the middle of a window
                push_event(OP_START, rand_sample(), 1'b1);
                repeat ($urandom_range(5)) push_event(OP_SAMPLE, rand_sample(), 1'b1);
                run_window(window_size());
            end
            else
            begin
                // open a window and leave it open
                push_event(OP_START, rand_sample(), 1'b1);
                repeat ($urandom_range(4)) push_event(OP_SAMPLE, rand_sample(), 1'b1);
            end
            // now and then, hold off until the block has caught up
            if ($urandom_range(9) == 0)
                drain_results();
        end
    endtask

    initial
    begin
        logic [CFG_DATA_W-1:0] lengths [4];
        lengths = '{16'd32, 16'd0, 16'd63, 16'hFFC6};

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, registers at their reset values, no idling.
        set_pace(0, 0);
        // empty window before any pressure: min reads 0, not yet valid
        push_event(OP_END, 12'hFFF, 1'b1);
        // sample with the window closed and the unused code: both dropped
        push_event(OP_SAMPLE, 12'hFFF, 1'b0);
        push_event(OP_UNUSED, 12'hAAA, 1'b0);
        push_event(OP_START, 12'h555, 1'b1);
        push_event(OP_SAMPLE, 12'h000, 1'b1);
        push_event(OP_END, 12'h000, 1'b1);
        // second end pushes the same window again
        push_event(OP_END, 12'hFFF, 1'b1);
        push_event(OP_START, 12'h000, 1'b1);
        push_event(OP_SAMPLE, 12'hFFF, 1'b1);
        push_event(OP_END, 12'h000, 1'b1);
        push_event(OP_START, 12'h000, 1'b1);
        push_event(OP_SAMPLE, 12'h001, 1'b1);
        push_event(OP_SAMPLE, 12'h002, 1'b1);
        push_event(OP_SAMPLE, 12'hFFF, 1'b1);
        push_event(OP_END, 12'h000, 1'b1);
        // empty window after results: minimum repeats, status flags it
        push_event(OP_START, 12'h000, 1'b1);
        push_event(OP_END, 12'h000, 1'b1);

        // Gain and offset extremes: saturate high, then pin to the floor.
        // Neither write clears the history.
        go_idle();
        write_reg(CFG_PRESSURE_GAIN, 16'hFFFF);
        write_reg(CFG_PRESSURE_OFFSET, 16'h7FFF);
        push_event(OP_START, 12'h000, 1'b1);
        push_event(OP_SAMPLE, 12'hFFF, 1'b1);
        push_event(OP_END, 12'h000, 1'b1);
        go_idle();
        write_reg(CFG_PRESSURE_GAIN, 16'h0000);
        write_reg(CFG_PRESSURE_OFFSET, 16'h8000);
        run_window(1);

        // Length clamps: zero becomes one, anything over the depth becomes
        // the depth; each write clears the history.
        go_idle();
        write_reg(CFG_BUFFER_LENGTH, 16'd0);
        run_window(2);
        go_idle();
        write_reg(CFG_BUFFER_LENGTH, 16'd40);
        write_reg(CFG_PRESSURE_GAIN, GAIN_RESET);
        run_window(3);

        // A long window, closed twice.
        push_event(OP_START, rand_sample(), 1'b1);
        repeat (40) push_event(OP_SAMPLE, rand_sample(), 1'b1);
        push_event(OP_END, rand_sample(), 1'b1);
        push_event(OP_END, rand_sample(), 1'b1);

        // Random part: each segment picks a pacing mode and new registers.
        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            go_idle();
            case (seg % 4)
                0:       set_pace(0, 0);
                1:       set_pace(83, 0);
                2:       set_pace(0, 83);
                default: set_pace(13, 13);
            endcase
            // length on even segments only, so odd ones keep the history
            if (seg % 2 == 0)
                write_reg(CFG_BUFFER_LENGTH, lengths[seg / 2]);
            case (seg)
                0:
                begin
                    write_reg(CFG_PRESSURE_GAIN, 16'hFFFF);
                    write_reg(CFG_PRESSURE_OFFSET, 16'h8000);
                end
                1:
                begin
                    write_reg(CFG_PRESSURE_GAIN, 16'h0000);
                    write_reg(CFG_PRESSURE_OFFSET, 16'h7FFF);
                end
                2:
                begin
                    write_reg(CFG_PRESSURE_GAIN, GAIN_RESET);
                    write_reg(CFG_PRESSURE_OFFSET, 16'h0000);
                end
                default:
                begin
                    write_reg(CFG_PRESSURE_GAIN, CFG_DATA_W'($urandom_range(65535)));
                    write_reg(CFG_PRESSURE_OFFSET, CFG_DATA_W'($urandom_range(65535)));
                end
            endcase
            random_traffic(SEGMENT_ITEMS);
        end

        // Wrap up: wait out every pending result plus the block's latency.
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- window_average_running_min.f -----
+incdir+sv
sv/war_pkg.sv
sv/window_average_running_min.sv
sv/war_checker.sv
tb/sv/window_min_checker.sv
tb/sv/tb_top.sv
